@@ design/polyline_arc_resampler_core_assert.svh @@
// Assertion macros used by the resampler command queue.
`ifndef POLYLINE_ARC_RESAMPLER_CORE_ASSERT_SVH
`define POLYLINE_ARC_RESAMPLER_CORE_ASSERT_SVH

// Checked outside reset only.
`define PARC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define PARC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/parc_pkg.sv @@
// Types and constants shared by the polyline arc resampler.
package parc_pkg;

    localparam int CoordW     = 32;
    localparam int SpacingW   = 24;
    localparam int PosW       = 48;
    localparam int SegW       = 33;
    localparam int SqW        = 66;
    localparam int CountW     = 6;
    localparam int QueueDepth = 2;

    localparam logic [SpacingW-1:0] SpacingReset = 24'd256;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex_x;
        logic signed [CoordW-1:0] vertex_y;
        logic                     first_vertex;
        logic                     final_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic                     run_end;
        logic                     line_end;
        logic                     overflow;
    } t_point;

    // One classified vertex, handed from front to back.
    typedef struct packed {
        logic                first;
        logic                fin;
        logic                ovf;
        logic [CountW-1:0]   count;
        logic [CoordW-1:0]   vert_x;
        logic [CoordW-1:0]   vert_y;
        logic [CoordW-1:0]   prev_x;
        logic [CoordW-1:0]   prev_y;
        logic                neg_x;
        logic                neg_y;
        logic [CoordW-1:0]   abs_x;
        logic [CoordW-1:0]   abs_y;
        logic [SegW-1:0]     seg;
        logic [SegW-1:0]     gap;
        logic [SpacingW-1:0] spacing;
    } t_cmd;

endpackage

@@ design/parc_front.sv @@
// Front end: segment length, sample count and arc state per vertex.
module parc_front #(
    parameter int MAX_RUN = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  parc_pkg::t_vertex i_vertex,
    input  logic [23:0]       i_spacing,
    output logic              o_cmd_push,
    input  logic              i_cmd_full,
    output parc_pkg::t_cmd    o_cmd
);

    localparam int CW = parc_pkg::CountW;
    localparam int PW = parc_pkg::PosW;
    localparam int SW = parc_pkg::SegW;
    localparam int QW = parc_pkg::SqW;
    localparam logic [CW-1:0] RunMax = CW'(MAX_RUN);

    typedef enum logic [2:0] {
        F_IDLE, F_SQ, F_SUM, F_SQRT, F_GAP, F_DIV, F_PUSH
    } t_fstate;

    t_fstate      r_state;
    logic [31:0]  r_prev_x, r_prev_y;
    logic [PW-1:0] r_arc, r_nsp, r_gap;
    logic [31:0]  r_vx, r_vy, r_ax, r_ay;
    logic         r_negx, r_negy, r_first, r_fin, r_has;
    logic [63:0]  r_sqx, r_sqy;
    logic [QW-1:0] r_rad;
    logic [35:0]  r_rem;
    logic [SW-1:0] r_root;
    logic [5:0]   r_iter;
    logic [SW-1:0] r_num, r_diff, r_quo;
    logic [24:0]  r_drem;
    logic [23:0]  r_sp;

    logic [32:0]  dx, dy, adx, ady;
    logic [35:0]  sq_t, sq_trial;
    logic [PW-1:0] gap, seg48;
    logic [24:0]  dv_t;
    logic         ovf;
    logic [CW-1:0] count;

    assign dx  = {i_vertex.vertex_x[31], i_vertex.vertex_x} - {r_prev_x[31], r_prev_x};
    assign dy  = {i_vertex.vertex_y[31], i_vertex.vertex_y} - {r_prev_y[31], r_prev_y};
    assign adx = dx[32] ? (~dx + 33'd1) : dx;
    assign ady = dy[32] ? (~dy + 33'd1) : dy;

    // two radicand bits per step
    assign sq_t     = {r_rem[33:0], r_rad[QW-1:QW-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    assign gap   = r_nsp - r_arc;
    assign seg48 = PW'(r_root);
    assign dv_t  = {r_drem[23:0], r_num[SW-1]};

    assign ovf   = r_has && (r_quo >= SW'(MAX_RUN));
    assign count = !r_has ? '0 : (ovf ? RunMax : CW'(r_quo + SW'(1)));

    assign o_full     = (r_state != F_IDLE);
    assign o_cmd_push = (r_state == F_PUSH) && !i_cmd_full;

    always_comb begin
        o_cmd.first   = r_first;
        o_cmd.fin     = r_fin;
        o_cmd.ovf     = r_first ? 1'b0 : ovf;
        o_cmd.count   = r_first ? '0 : count;
        o_cmd.vert_x  = r_vx;
        o_cmd.vert_y  = r_vy;
        o_cmd.prev_x  = r_prev_x;
        o_cmd.prev_y  = r_prev_y;
        o_cmd.neg_x   = r_negx;
        o_cmd.neg_y   = r_negy;
        o_cmd.abs_x   = r_ax;
        o_cmd.abs_y   = r_ay;
        o_cmd.seg     = r_root;
        o_cmd.gap     = r_gap[SW-1:0];
        o_cmd.spacing = r_sp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_arc    <= '0;
            r_nsp    <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_vx    <= i_vertex.vertex_x;
                        r_vy    <= i_vertex.vertex_y;
                        r_first <= i_vertex.first_vertex;
                        r_fin   <= i_vertex.final_vertex;
                        r_sp    <= (i_spacing == '0) ? 24'd1 : i_spacing;
                        r_ax    <= adx[31:0];
                        r_ay    <= ady[31:0];
                        r_negx  <= dx[32];
                        r_negy  <= dy[32];
                        r_has   <= 1'b0;
                        r_state <= i_vertex.first_vertex ? F_PUSH : F_SQ;
                    end
                end
                F_SQ: begin
                    r_sqx   <= r_ax * r_ax;
                    r_sqy   <= r_ay * r_ay;
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    r_rad   <= QW'(r_sqx) + QW'(r_sqy);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_iter  <= 6'd32;
                    r_state <= F_SQRT;
                end
                F_SQRT: begin
                    if (sq_t >= sq_trial) begin
                        r_rem  <= sq_t - sq_trial;
                        r_root <= {r_root[SW-2:0], 1'b1};
                    end else begin
                        r_rem  <= sq_t;
                        r_root <= {r_root[SW-2:0], 1'b0};
                    end
                    r_rad  <= {r_rad[QW-3:0], 2'b00};
                    r_iter <= r_iter - 6'd1;
                    if (r_iter == '0) begin
                        r_state <= F_GAP;
                    end
                end
                F_GAP: begin
                    r_gap <= gap;
                    if (seg48 >= gap) begin
                        r_has   <= 1'b1;
                        r_num   <= SW'(seg48 - gap);
                        r_diff  <= SW'(seg48 - gap);
                        r_drem  <= '0;
                        r_quo   <= '0;
                        r_iter  <= 6'd32;
                        r_state <= F_DIV;
                    end else begin
                        r_state <= F_PUSH;
                    end
                end
                F_DIV: begin
                    if (dv_t >= {1'b0, r_sp}) begin
                        r_drem <= dv_t - {1'b0, r_sp};
                        r_quo  <= {r_quo[SW-2:0], 1'b1};
                    end else begin
                        r_drem <= dv_t;
                        r_quo  <= {r_quo[SW-2:0], 1'b0};
                    end
                    r_num  <= {r_num[SW-2:0], 1'b0};
                    r_iter <= r_iter - 6'd1;
                    if (r_iter == '0) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_cmd_full) begin
                        r_prev_x <= r_vx;
                        r_prev_y <= r_vy;
                        if (r_first) begin
                            r_arc <= '0;
                            r_nsp <= PW'(r_sp);
                        end else begin
                            r_arc <= r_arc + seg48;
                            // n * spacing = diff - remainder + spacing
                            if (r_has) begin
                                r_nsp <= r_nsp + PW'(r_diff) - PW'(r_drem) + PW'(r_sp);
                            end
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

@@ design/parc_queue.sv @@
// Short command queue between front and back.
`include "polyline_arc_resampler_core_assert.svh"
module parc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  parc_pkg::t_cmd i_data,
    output logic           o_empty,
    input  logic           i_pop,
    output parc_pkg::t_cmd o_data
);

    localparam int D  = parc_pkg::QueueDepth;
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    parc_pkg::t_cmd r_mem [D];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(D));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(D - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(D - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `PARC_ASSERT_ALWAYS(a_count_max, (!i_rst_n || r_count <= CW'(D)), "queue overfilled")
    `PARC_ASSERT(a_push_grows, (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)), "push lost")
    `PARC_ASSERT(a_pop_shrinks, (do_pop && !do_push) |=> (r_count == $past(r_count) - CW'(1)), "pop lost")

endmodule

@@ design/parc_back.sv @@
// Back end: interpolates samples and drives the result register.
module parc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  parc_pkg::t_cmd i_cmd,
    output logic           o_empty,
    input  logic           i_pop,
    output parc_pkg::t_point o_point
);

    localparam int SW = parc_pkg::SegW;
    localparam int QW = parc_pkg::SqW;
    localparam int CW = parc_pkg::CountW;

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_EMIT, B_VERT} t_bstate;

    t_bstate          r_state;
    parc_pkg::t_cmd   r_cmd;
    logic [CW-1:0]    r_k;
    logic [SW-1:0]    r_pos;
    logic [SW-1:0]    r_rem [2];
    logic [31:0]      r_nlo [2];
    logic [31:0]      r_quo [2];
    logic [4:0]       r_iter;
    parc_pkg::t_point r_out;
    logic             r_out_valid;

    logic [31:0]   ax [2];
    logic [31:0]   px [2];
    logic          neg [2];
    logic [QW-1:0] num [2];
    logic [SW:0]   dv_t [2];
    logic [31:0]   res [2];
    logic          out_free, out_load, last;

    assign ax[0]  = r_cmd.abs_x;
    assign ax[1]  = r_cmd.abs_y;
    assign px[0]  = r_cmd.prev_x;
    assign px[1]  = r_cmd.prev_y;
    assign neg[0] = r_cmd.neg_x;
    assign neg[1] = r_cmd.neg_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // |d| * pos + floor(seg / 2), pos split at bit 32
            num[l] = QW'(ax[l] * r_pos[31:0])
                   + (r_pos[32] ? {2'b00, ax[l], 32'd0} : '0)
                   + QW'(r_cmd.seg >> 1);
            dv_t[l] = {r_rem[l], r_nlo[l][31]};
            if (r_cmd.seg == '0) begin
                res[l] = px[l];
            end else if (neg[l]) begin
                res[l] = px[l] - r_quo[l];
            end else begin
                res[l] = px[l] + r_quo[l];
            end
        end
    end

    assign out_free  = !r_out_valid || i_pop;
    // result register takes a new point this cycle
    assign out_load  = out_free && ((r_state == B_EMIT) || (r_state == B_VERT));
    assign last      = (r_k == r_cmd.count - CW'(1));
    assign o_cmd_pop = (r_state == B_IDLE) && !i_cmd_empty;
    assign o_empty   = !r_out_valid;
    assign o_point   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd <= i_cmd;
                        r_k   <= '0;
                        r_pos <= i_cmd.gap;
                        if (i_cmd.first) begin
                            r_state <= B_VERT;
                        end else if (i_cmd.count != '0) begin
                            r_state <= B_MUL;
                        end else if (i_cmd.fin) begin
                            r_state <= B_VERT;
                        end
                    end
                end
                B_MUL: begin
                    for (int l = 0; l < 2; l++) begin
                        r_rem[l] <= num[l][QW-2:32];
                        r_nlo[l] <= num[l][31:0];
                        r_quo[l] <= '0;
                    end
                    r_iter  <= 5'd31;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    for (int l = 0; l < 2; l++) begin
                        if (dv_t[l] >= {1'b0, r_cmd.seg}) begin
                            r_rem[l] <= SW'(dv_t[l] - {1'b0, r_cmd.seg});
                            r_quo[l] <= {r_quo[l][30:0], 1'b1};
                        end else begin
                            r_rem[l] <= SW'(dv_t[l]);
                            r_quo[l] <= {r_quo[l][30:0], 1'b0};
                        end
                        r_nlo[l] <= {r_nlo[l][30:0], 1'b0};
                    end
                    r_iter <= r_iter - 5'd1;
                    if (r_iter == '0) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        r_out.point_x  <= res[0];
                        r_out.point_y  <= res[1];
                        r_out.run_end  <= last && !r_cmd.fin;
                        r_out.line_end <= 1'b0;
                        r_out.overflow <= r_cmd.ovf;
                        r_out_valid    <= 1'b1;
                        r_k            <= r_k + CW'(1);
                        r_pos          <= r_pos + SW'(r_cmd.spacing);
                        if (!last) begin
                            r_state <= B_MUL;
                        end else if (r_cmd.fin) begin
                            r_state <= B_VERT;
                        end else begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                B_VERT: begin
                    if (out_free) begin
                        r_out.point_x  <= r_cmd.vert_x;
                        r_out.point_y  <= r_cmd.vert_y;
                        r_out.run_end  <= 1'b1;
                        r_out.line_end <= r_cmd.fin;
                        r_out.overflow <= r_cmd.ovf;
                        r_out_valid    <= 1'b1;
                        r_state        <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

@@ design/polyline_arc_resampler_core.sv @@
// Polyline arc-length resampler, top level.
//
// Vertices come in on a queue-style port: a transfer happens at a clock edge
// with i_push high and o_full low. Results leave the same way: the oldest
// point sits on o_point while o_empty is low and is taken by i_pop.
// i_cfg_we writes the sample spacing (1/256 m, 0 acts as 1); write it only
// while the block is idle.
//
// For each resampled vertex the front end steps through accept, square, sum,
// 33-step square root, gap, 33-step sample-count divide (skipped when the
// segment ends before the next sample) and push; a first vertex goes from
// accept straight to push. The back end handles each interpolated point in
// one multiply, a 32-step divide (x and y in parallel) and emit, and emits a
// vertex echo on its own. A two-entry queue between them lets the front
// classify the next vertex while the back is still emitting.
//
// Reset clears all arc state, empties the queue and the output register and
// sets the spacing to 256. If the receiver stops popping, the back end and
// then the front stall, o_full stays high, and nothing is dropped.
module polyline_arc_resampler_core #(
    parameter int MAX_RUN = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  parc_pkg::t_vertex  i_vertex,
    output logic               o_empty,
    input  logic               i_pop,
    output parc_pkg::t_point   o_point,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_data
);

    logic [23:0]    r_spacing;
    logic           cmd_push, cmd_full, cmd_empty, cmd_pop;
    parc_pkg::t_cmd cmd_in, cmd_out;

    // spacing register, written directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= parc_pkg::SpacingReset;
        end else if (i_cfg_we) begin
            r_spacing <= i_cfg_data;
        end
    end

    // front: length, sample count and arc bookkeeping
    parc_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_vertex   (i_vertex),
        .i_spacing  (r_spacing),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full),
        .o_cmd      (cmd_in)
    );

    // decouples classification from interpolation
    parc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .o_full  (cmd_full),
        .i_data  (cmd_in),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out)
    );

    // back: interpolation and the result register
    parc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd_out),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_point     (o_point)
    );

endmodule

@@ bench/parc_checker.sv @@
// Checker for the arc resampler: predicts the output points and compares them.
module parc_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  parc_pkg::t_vertex i_vertex,
    input  logic              i_empty,
    input  logic              i_pop,
    input  parc_pkg::t_point  i_point,
    input  logic              i_cfg_we,
    input  logic [23:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxRun = 63;

    logic [parc_pkg::CoordW-1:0]   last_x, last_y;
    logic [parc_pkg::PosW-1:0]     arc_len, sample_at;
    logic [parc_pkg::SpacingW-1:0] spacing_reg;
    parc_pkg::t_point              point_q[$];

    function automatic logic [33:0] root_of(input logic [67:0] v);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if (68'(c) * 68'(c) <= v) r = c;
        end
        return r;
    endfunction

    // Rounded to nearest, ties away from zero.
    function automatic logic [63:0] lerp(input longint p, input longint d,
                                         input logic [63:0] pos, input logic [63:0] seg);
        logic [127:0] num;
        logic [63:0]  ad;
        logic [63:0]  q;
        if (seg == 0) return p;
        ad  = (d < 0) ? -d : d;
        num = 128'(ad) * 128'(pos) + 128'(seg >> 1);
        q   = 64'(num / 128'(seg));
        return (d < 0) ? p - q : p + q;
    endfunction

    task automatic predict_points(input parc_pkg::t_vertex v);
        logic [63:0]      step, seg, gap, n, pos;
        longint           px, py, dx, dy, ax, ay;
        parc_pkg::t_point pt;
        int               cnt;
        step = (spacing_reg == 0) ? 64'd1 : 64'(spacing_reg);
        if (v.first_vertex) begin
            pt = '{v.vertex_x, v.vertex_y, 1'b1, v.final_vertex, 1'b0};
            point_q = {point_q, pt};
            last_x    = v.vertex_x;
            last_y    = v.vertex_y;
            arc_len   = '0;
            sample_at = step[parc_pkg::PosW-1:0];
            return;
        end
        px  = longint'($signed(last_x));
        py  = longint'($signed(last_y));
        dx  = longint'(v.vertex_x) - px;
        dy  = longint'(v.vertex_y) - py;
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        seg = 64'(root_of(68'(ax) * 68'(ax) + 68'(ay) * 68'(ay)));
        gap = 64'(parc_pkg::PosW'(sample_at - arc_len));
        n   = (seg >= gap) ? (seg - gap) / step + 1 : 64'd0;
        cnt = 0;
        for (int k = 0; k < MaxRun && k < n; k++) begin
            pos = gap + 64'(k) * step;
            pt  = '{32'(lerp(px, dx, pos, seg)), 32'(lerp(py, dy, pos, seg)),
                    1'b0, 1'b0, n > MaxRun};
            point_q = {point_q, pt};
            cnt++;
        end
        if (v.final_vertex) begin
            pt = '{v.vertex_x, v.vertex_y, 1'b0, 1'b1, n > MaxRun};
            point_q = {point_q, pt};
            cnt++;
        end
        if (cnt > 0) point_q[$].run_end = 1'b1;
        sample_at = parc_pkg::PosW'(64'(sample_at) + n * step);
        arc_len   = parc_pkg::PosW'(64'(arc_len) + seg);
        last_x    = v.vertex_x;
        last_y    = v.vertex_y;
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = point_q.size();

    always @(posedge i_clk) begin
        parc_pkg::t_point want;
        if (!i_rst_n) begin
            last_x      = '0;
            last_y      = '0;
            arc_len     = '0;
            sample_at   = '0;
            spacing_reg = parc_pkg::SpacingReset;
            point_q.delete();
        end else begin
            if (i_cfg_we) spacing_reg = i_cfg_data;
            if (i_pop && !i_empty) begin
                if (point_q.size() == 0) begin
                    report("unexpected point", i_point.point_x, 32'd0);
                end else begin
                    want = point_q.pop_front();
                    if (i_point.point_x !== want.point_x)
                        report("point_x", i_point.point_x, want.point_x);
                    if (i_point.point_y !== want.point_y)
                        report("point_y", i_point.point_y, want.point_y);
                    if (i_point.run_end !== want.run_end)
                        report("run_end", 32'(i_point.run_end), 32'(want.run_end));
                    if (i_point.line_end !== want.line_end)
                        report("line_end", 32'(i_point.line_end), 32'(want.line_end));
                    if (i_point.overflow !== want.overflow)
                        report("overflow", 32'(i_point.overflow), 32'(want.overflow));
                end
            end
            // Pop is handled first: a vertex accepted now cannot emit before the next edge.
            if (i_push && !i_full) predict_points(i_vertex);
        end
    end
endmodule

@@ bench/tb.sv @@
// Testbench top for the arc resampler: stimulus, pacing and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Margin covering the front end and the back end before the first point.
    localparam int Settle     = 300;
    localparam int CycleLimit = 20000000;
    localparam int RandItems  = 350;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_push = 1'b0;
    logic              o_full;
    parc_pkg::t_vertex i_vertex = '0;
    logic              o_empty;
    logic              i_pop = 1'b0;
    parc_pkg::t_point  o_point;
    logic              i_cfg_we = 1'b0;
    logic [23:0]       i_cfg_data = '0;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    logic              stim_done = 1'b0;

    polyline_arc_resampler_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_vertex   (i_vertex),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_point    (o_point),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    parc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_full       (o_full),
        .i_vertex     (i_vertex),
        .i_empty      (o_empty),
        .i_pop        (i_pop),
        .i_point      (o_point),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop if the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: bursts of pop with random stalls between them.
    always begin
        int burst, stall;
        @(negedge i_clk);
        if (stim_done || !i_rst_n) begin
            i_pop <= 1'b1;
        end else begin
            burst = $urandom_range(1, 20);
            stall = idle_len();
            i_pop <= 1'b1;
            repeat (burst) @(negedge i_clk);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // One vertex transfer, then an optional idle gap on the push side.
    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic first, input logic fin);
        int gap;
        @(negedge i_clk);
        i_push   <= 1'b1;
        i_vertex <= '{x, y, first, fin};
        do @(posedge i_clk); while (o_full);
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Spacing write only once the block has drained.
    task automatic set_spacing(input logic [23:0] value);
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (Settle) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A polyline of random content; steps scaled to the spacing so samples stay few.
    task automatic random_line(input int nverts, input logic [23:0] sp);
        logic [31:0] x, y;
        int          reach;
        reach = (sp == 0) ? 4 : ((sp > 24'h3FFFFF) ? 32'h3FFFFFFF : 4 * sp);
        x = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 65535) - 32768;
        y = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 65535) - 32768;
        send_vertex(x, y, 1'b1, nverts == 1);
        for (int k = 1; k < nverts; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = x + ($urandom_range(0, 1) ? $urandom_range(0, reach)
                                                : -$urandom_range(0, reach));
                y = y + ($urandom_range(0, 1) ? $urandom_range(0, reach)
                                                : -$urandom_range(0, reach));
            end
            send_vertex(x, y, 1'b0, k == nverts - 1);
        end
    endtask

    initial begin
        logic [23:0] sp;
        int          sent;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Vertex with no first flag after reset: continues from the origin.
        send_vertex(32'd100, 32'd0, 1'b0, 1'b0);
        // One-vertex polyline at the extremes.
        send_vertex(32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1);
        // Full-diagonal segment overflows the run.
        send_vertex(32'h80000000, 32'h80000000, 1'b1, 1'b0);
        send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b1);
        // Zero-length segments, then continuing after a final vertex.
        send_vertex(32'd5, 32'd5, 1'b1, 1'b0);
        send_vertex(32'd5, 32'd5, 1'b0, 1'b0);
        send_vertex(32'd5, 32'd5, 1'b0, 1'b1);
        send_vertex(32'd305, 32'd405, 1'b0, 1'b0);
        send_vertex(-32'd200, 32'd405, 1'b0, 1'b1);

        set_spacing(24'd1);
        send_vertex(32'd0, 32'd0, 1'b1, 1'b0);
        send_vertex(32'd40, -32'd30, 1'b0, 1'b0);
        send_vertex(32'd140, -32'd30, 1'b0, 1'b1);
        set_spacing(24'd0);
        send_vertex(32'd10, 32'd10, 1'b1, 1'b0);
        send_vertex(32'd13, 32'd14, 1'b0, 1'b1);
        set_spacing(24'hFFFFFF);
        send_vertex(32'd0, 32'd0, 1'b1, 1'b0);
        send_vertex(32'h7FFFFFFF, -32'd1, 1'b0, 1'b0);
        // Spacing changed mid-polyline keeps the pending position.
        set_spacing(24'd1000);
        send_vertex(32'h7FFFF000, 32'd2000, 1'b0, 1'b1);

        sent = 0;
        while (sent < RandItems) begin
            case ($urandom_range(0, 5))
                0:       sp = 24'hFFFFFF;
                1:       sp = $urandom_range(1, 8);
                2:       sp = $urandom;
                default: sp = $urandom_range(16, 4096);
            endcase
            set_spacing(sp);
            for (int k = 0; k < 6 && sent < RandItems; k++) begin
                int nv;
                nv = $urandom_range(1, 8);
                random_line(nv, sp);
                sent += nv;
            end
        end

        @(negedge i_clk);
        i_push <= 1'b0;
        stim_done <= 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/parc_pkg.sv
design/parc_front.sv
design/parc_queue.sv
design/parc_back.sv
design/polyline_arc_resampler_core.sv
bench/parc_checker.sv
bench/tb.sv
